/* hdl/sps_pkg.sv */
package sps_pkg;

    localparam int MAX_POSITIONS = 256;
    localparam int MAX_PATTERNS  = 256;
    localparam int MAX_LINES     = 256;

    localparam int POS_AW  = $clog2(MAX_POSITIONS);
    localparam int PAT_AW  = $clog2(MAX_PATTERNS);
    localparam int POS_W   = 9;
    localparam int SCAN_W  = POS_W + 1;
    localparam int PATN_W  = 8;
    localparam int LINE_W  = 8;
    localparam int LEN_W   = 9;
    localparam int MODE_W  = 3;
    localparam int IDX_W   = 8;
    localparam int VAL_W   = 9;
    localparam int CFG_AW  = 1;
    localparam int CFG_DW  = 9;

    localparam logic [MODE_W-1:0] MODE_ADVANCE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_ORDER  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD_LENGTH = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOAD_SELECT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_START       = 3'd4;

    localparam logic [CFG_AW-1:0] CFG_SONG_LENGTH = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_BLOCK_MODE  = 1'd1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  entry_index;
        logic [VAL_W-1:0]  entry_value;
    } t_item;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [PATN_W-1:0] pattern;
        logic [LINE_W-1:0] line;
        logic              pattern_changed;
        logic              song_wrapped;
    } t_result;

endpackage

/* hdl/sps_table_ram.sv */
module sps_table_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/song_position_sequencer_core.sv */
// Load and unused items finish from idle; an advance reads the length table, and at pattern
// end then the order table, in block mode after a scan of positions with one select flag
// tested per select table read; a start reads the order table. Throughput: one item at a
// time; the next item may be accepted in the cycle of the strobe. Reset clears position,
// pattern, line, block mode and select flags and sets song length to 1; order and length
// tables hold nothing until loaded. The receiver cannot stall: each result shows for one cycle.
module song_position_sequencer_core
    import sps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_item             i_item,
    output logic              o_busy,
    output logic              o_done,
    output t_result           o_result,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_LEN      = 3'd1;
    localparam logic [2:0] ST_SCAN_RD  = 3'd2;
    localparam logic [2:0] ST_SCAN_CHK = 3'd3;
    localparam logic [2:0] ST_ORD_RD   = 3'd4;
    localparam logic [2:0] ST_ORD_DONE = 3'd5;

    localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(MAX_POSITIONS);
    localparam logic [POS_W-1:0]  POS_END  = POS_W'(MAX_POSITIONS);

    logic [2:0]             r_state;
    logic                   r_done;
    logic [POS_W-1:0]       r_song_length;
    logic                   r_block_mode;
    logic [MAX_POSITIONS-1:0] r_sel_valid;
    logic [POS_W-1:0]       r_cur_position;
    logic [PATN_W-1:0]      r_cur_pattern;
    logic [LINE_W-1:0]      r_cur_line;

    logic [SCAN_W-1:0]      r_scan;
    logic [POS_W-1:0]       r_limit;
    logic                   r_wrap;
    logic                   r_ord_ok;
    logic                   r_sel_vld;
    logic                   r_changed;
    logic                   r_wrapped;

    logic                   accept;
    logic [POS_W-1:0]       bound;
    logic [LINE_W:0]        line_next;
    logic                   line_end;
    logic [SCAN_W-1:0]      pos_next;
    logic                   scan_stop;
    logic                   sel_hit;

    logic [PATN_W-1:0]      order_rdata;
    logic [LEN_W-1:0]       len_rdata;
    logic                   sel_rdata;

    assign accept    = i_start && (r_state == ST_IDLE);
    assign bound     = (r_song_length > POS_END) ? POS_END : r_song_length;
    assign line_next = {1'b0, r_cur_line} + (LINE_W+1)'(1);
    assign line_end  = ({1'b0, line_next} >= {1'b0, len_rdata}) || line_next[LINE_W];
    assign pos_next  = {1'b0, r_cur_position} + SCAN_W'(1);
    assign scan_stop = r_scan >= {1'b0, r_limit};
    assign sel_hit   = sel_rdata && r_sel_vld;

    sps_table_ram #(.WIDTH(PATN_W), .DEPTH(MAX_POSITIONS)) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (accept && (i_item.mode == MODE_LOAD_ORDER)),
        .i_waddr (i_item.entry_index[POS_AW-1:0]),
        .i_wdata (i_item.entry_value[PATN_W-1:0]),
        .i_re    (r_state == ST_ORD_RD),
        .i_raddr (r_scan[POS_AW-1:0]),
        .o_rdata (order_rdata)
    );

    sps_table_ram #(.WIDTH(LEN_W), .DEPTH(MAX_PATTERNS)) u_length_ram (
        .i_clk   (i_clk),
        .i_we    (accept && (i_item.mode == MODE_LOAD_LENGTH)),
        .i_waddr (i_item.entry_index[PAT_AW-1:0]),
        .i_wdata (i_item.entry_value[LEN_W-1:0]),
        .i_re    (accept && (i_item.mode == MODE_ADVANCE)),
        .i_raddr (r_cur_pattern[PAT_AW-1:0]),
        .o_rdata (len_rdata)
    );

    sps_table_ram #(.WIDTH(1), .DEPTH(MAX_POSITIONS)) u_select_ram (
        .i_clk   (i_clk),
        .i_we    (accept && (i_item.mode == MODE_LOAD_SELECT)),
        .i_waddr (i_item.entry_index[POS_AW-1:0]),
        .i_wdata (i_item.entry_value[0]),
        .i_re    (r_state == ST_SCAN_RD),
        .i_raddr (r_scan[POS_AW-1:0]),
        .o_rdata (sel_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_done         <= 1'b0;
            r_song_length  <= POS_W'(1);
            r_block_mode   <= 1'b0;
            r_sel_valid    <= '0;
            r_cur_position <= '0;
            r_cur_pattern  <= '0;
            r_cur_line     <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SONG_LENGTH: r_song_length <= i_cfg_data[POS_W-1:0];
                    CFG_BLOCK_MODE:  r_block_mode  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (i_item.mode)
                            MODE_ADVANCE: begin
                                r_state <= ST_LEN;
                            end
                            MODE_START: begin
                                r_cur_line <= i_item.entry_value[LINE_W-1:0];
                                r_state    <= ST_ORD_RD;
                            end
                            MODE_LOAD_SELECT: begin
                                r_sel_valid[i_item.entry_index[POS_AW-1:0]] <= 1'b1;
                                r_done <= 1'b1;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_LEN: begin
                    if (line_end) begin
                        r_cur_line <= '0;
                        r_state    <= r_block_mode ? ST_SCAN_RD : ST_ORD_RD;
                    end else begin
                        r_cur_line <= line_next[LINE_W-1:0];
                        r_done     <= 1'b1;
                        r_state    <= ST_IDLE;
                    end
                end
                ST_SCAN_RD: begin
                    if (!scan_stop) begin
                        r_state <= ST_SCAN_CHK;
                    end else if (r_wrap) begin
                        r_state <= ST_ORD_RD;
                    end
                end
                ST_SCAN_CHK: begin
                    r_state <= sel_hit ? ST_ORD_RD : ST_SCAN_RD;
                end
                ST_ORD_RD: begin
                    r_state <= ST_ORD_DONE;
                end
                ST_ORD_DONE: begin
                    r_cur_position <= r_scan[POS_W-1:0];
                    r_cur_pattern  <= r_ord_ok ? order_rdata : '0;
                    r_done         <= 1'b1;
                    r_state        <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_scan    <= {2'b00, i_item.entry_index};
                    r_wrap    <= 1'b0;
                    r_changed <= (i_item.mode == MODE_START);
                    r_wrapped <= 1'b0;
                end
            end
            ST_LEN: begin
                r_changed <= line_end;
                r_wrapped <= 1'b0;
                if (r_block_mode) begin
                    r_scan  <= pos_next;
                    r_limit <= POS_END;
                    r_wrap  <= 1'b0;
                end else if (pos_next >= {1'b0, bound}) begin
                    r_scan <= '0;
                    r_wrap <= 1'b1;
                end else begin
                    r_scan <= pos_next;
                    r_wrap <= 1'b0;
                end
            end
            ST_SCAN_RD: begin
                r_sel_vld <= r_sel_valid[r_scan[POS_AW-1:0]];
                if (scan_stop && !r_wrap) begin
                    r_scan  <= '0;
                    r_limit <= bound;
                    r_wrap  <= 1'b1;
                end
            end
            ST_SCAN_CHK: begin
                if (!sel_hit) begin
                    r_scan <= r_scan + SCAN_W'(1);
                end
            end
            ST_ORD_RD: begin
                r_ord_ok <= r_scan < SCAN_END;
            end
            ST_ORD_DONE: begin
                r_wrapped <= r_wrap;
            end
            default: ;
        endcase
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = '{position:        r_cur_position,
                        pattern:         r_cur_pattern,
                        line:            r_cur_line,
                        pattern_changed: r_changed,
                        song_wrapped:    r_wrapped};

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while busy");

    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.mode == MODE_LOAD_ORDER || i_item.mode == MODE_LOAD_LENGTH ||
                   i_item.mode == MODE_LOAD_SELECT) |=> o_done && !o_result.pattern_changed)
        else $error("load item not reported in one cycle");

    a_wrap_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.song_wrapped |-> o_result.pattern_changed)
        else $error("wrap without position change");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN_CHK |-> $past(r_state) == ST_SCAN_RD)
        else $error("select check without a select read");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN_CHK |-> r_scan < SCAN_END)
        else $error("select read beyond the table");

endmodule
